// ----- src/strided_gather_address_generator_defines.svh -----
// Assertion macros shared by the strided gather address generator RTL.
`ifndef STRIDED_GATHER_ADDRESS_GENERATOR_DEFINES_SVH
`define STRIDED_GATHER_ADDRESS_GENERATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define SGAG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sgag: same-cycle check failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define SGAG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sgag: next-cycle check failed");

`endif

// ----- src/sgag_pkg.sv -----
// Shared constants, types and helpers of the strided gather address generator.
package sgag_pkg;

	localparam int MAX_DIMS   = 4;
	localparam int ELEM_BYTES = 4;
	localparam int NDIM_REGS  = 4;
	localparam int FIRST_DIM  = NDIM_REGS - MAX_DIMS;
	localparam int ADDR_W     = 48;
	localparam int EXT_W      = 16;
	localparam int STR_W      = 16;
	localparam int CFG_W      = 16;
	localparam int NUM_CFG    = 2 * NDIM_REGS;
	localparam int CFG_IDX_W  = $clog2(NUM_CFG);
	localparam int DIM_IDX_W  = $clog2(NDIM_REGS);

	// register map: extents first, then strides, outermost dimension first
	localparam int CFG_EXTENT_BASE = 0;
	localparam int CFG_STRIDE_BASE = NDIM_REGS;

	typedef logic [ADDR_W-1:0]       addr_t;
	typedef logic [EXT_W-1:0]        ext_t;
	typedef logic signed [STR_W-1:0] stride_t;
	typedef logic [DIM_IDX_W-1:0]    dim_idx_t;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_NEXT  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic  valid_res;
		addr_t src_addr;
		addr_t dst_addr;
		logic  last;
	} walk_res_t;

	// signed element stride to byte step, modulo 2^ADDR_W
	function automatic addr_t step_bytes(input stride_t s);
		addr_t sext;
		sext = ADDR_W'(s);
		return ADDR_W'(sext * ADDR_W'(ELEM_BYTES));
	endfunction

endpackage

// ----- src/sgag_contig.sv -----
// Contiguity check: are the strides the packed row-major strides of the extents.
module sgag_contig (
	input  sgag_pkg::ext_t    extent [sgag_pkg::NDIM_REGS],
	input  sgag_pkg::stride_t stride [sgag_pkg::NDIM_REGS],
	output logic              contiguous
);
	import sgag_pkg::*;

	localparam int PROD_W = 2 * EXT_W;

	logic [PROD_W-1:0] expected [NDIM_REGS];

	// Outermost packed stride is e3*e2*e1. When e1 != 1 the check on the
	// next dimension already demands stride_1 == e3*e2, so stride_1*e1 stands
	// in for it; a mismatch there clears the flag anyway. Keeps the products
	// to parallel 16x16 multipliers.
	always_comb begin
		expected[3] = PROD_W'(1);
		expected[2] = PROD_W'(extent[3]);
		expected[1] = PROD_W'(extent[3]) * PROD_W'(extent[2]);
		if (extent[1] == EXT_W'(1)) begin
			expected[0] = expected[1];
		end else begin
			expected[0] = PROD_W'(unsigned'(stride[1])) * PROD_W'(extent[1]);
		end
	end

	always_comb begin
		contiguous = 1'b1;
		for (int d = 0; d < NDIM_REGS; d++) begin
			if (d >= FIRST_DIM && extent[d] != EXT_W'(1)) begin
				if (stride[d][STR_W-1] ||
				    PROD_W'(unsigned'(stride[d])) != expected[d]) begin
					contiguous = 1'b0;
				end
			end
		end
	end

endmodule

// ----- src/sgag_walk.sv -----
// Walk state: index counters, per-dimension offsets, running destination.
module sgag_walk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  sgag_pkg::cmd_t      cmd,
	input  sgag_pkg::addr_t     src_base,
	input  sgag_pkg::addr_t     dst_base,
	input  sgag_pkg::ext_t      extent [sgag_pkg::NDIM_REGS],
	input  sgag_pkg::stride_t   stride [sgag_pkg::NDIM_REGS],
	output sgag_pkg::walk_res_t res,
	output logic                walk_active
);
	import sgag_pkg::*;

	ext_t  idx_q [NDIM_REGS];
	addr_t off_q [NDIM_REGS];
	addr_t dst_q;
	logic  active_q;

	ext_t  idx_d [NDIM_REGS];
	addr_t off_d [NDIM_REGS];
	addr_t dst_d;
	logic  active_d;

	addr_t               sum [NDIM_REGS];
	logic [NDIM_REGS-1:0] inc_ok;
	logic                any_zero;
	logic                found;
	dim_idx_t            carry_dim;
	addr_t               new_off;

	// per-dimension candidates, all in parallel
	always_comb begin
		any_zero = 1'b0;
		for (int d = 0; d < NDIM_REGS; d++) begin
			sum[d]    = off_q[d] + step_bytes(stride[d]);
			inc_ok[d] = ((EXT_W+1)'(idx_q[d]) + (EXT_W+1)'(1)) < (EXT_W+1)'(extent[d]);
			if (d >= FIRST_DIM && extent[d] == '0) begin
				any_zero = 1'b1;
			end
		end
	end

	// innermost dimension that can still count up
	always_comb begin
		found     = 1'b0;
		carry_dim = '0;
		for (int d = NDIM_REGS - 1; d >= FIRST_DIM; d--) begin
			if (!found && inc_ok[d]) begin
				found     = 1'b1;
				carry_dim = DIM_IDX_W'(d);
			end
		end
		new_off = sum[carry_dim];
	end

	always_comb begin
		idx_d    = idx_q;
		off_d    = off_q;
		dst_d    = dst_q;
		active_d = active_q;
		res      = '0;
		unique case (cmd)
			CMD_START: begin
				active_d = !any_zero;
				for (int d = 0; d < NDIM_REGS; d++) begin
					idx_d[d] = '0;
					off_d[d] = src_base;
				end
				dst_d = dst_base;
			end
			CMD_NEXT: begin
				if (active_q && !any_zero) begin
					res.valid_res = 1'b1;
					res.src_addr  = off_q[NDIM_REGS-1];
					res.dst_addr  = dst_q;
					if (!found) begin
						res.last = 1'b1;
						active_d = 1'b0;
					end else begin
						for (int d = 0; d < NDIM_REGS; d++) begin
							if (DIM_IDX_W'(d) == carry_dim) begin
								idx_d[d] = idx_q[d] + EXT_W'(1);
								off_d[d] = new_off;
							end else if (DIM_IDX_W'(d) > carry_dim) begin
								idx_d[d] = '0;
								off_d[d] = new_off;
							end
						end
						dst_d = dst_q + ADDR_W'(ELEM_BYTES);
					end
				end else begin
					active_d = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (step) begin
			active_q <= active_d;
		end
	end

	// only read while a walk is active, and a start loads them all
	always_ff @(posedge clk) begin
		if (step) begin
			idx_q <= idx_d;
			off_q <= off_d;
			dst_q <= dst_d;
		end
	end

	assign walk_active = active_q;

endmodule

// ----- src/strided_gather_address_generator.sv -----
// Top level of the strided gather address generator.
//
//  channel  handshake            payload
//  -------  -------------------  ------------------------------------------------------
//  in       in_valid / in_stall  cmd, src_base, dst_base
//  out      out_valid/out_stall  valid_res, src_addr, dst_addr, last, already_contiguous
//  cfg      cfg_we               cfg_index, cfg_data (extent_0..3, stride_0..3)
//
// One request per cycle sustained while out_stall is low; a request passes the input
// register, then the result register, on its way to the output.
// The walk state turns over once per request, so the next-address add and the
// carry search across the four index counters set the path.
// arst_n resets the config registers to their defaults and empties both stages.
// in_stall rises only while the input stage is full and the result is stalled.
`include "strided_gather_address_generator_defines.svh"

module strided_gather_address_generator (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  sgag_pkg::addr_t       src_base,
	input  sgag_pkg::addr_t       dst_base,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  valid_res,
	output sgag_pkg::addr_t       src_addr,
	output sgag_pkg::addr_t       dst_addr,
	output logic                  last,
	output logic                  already_contiguous,
	// config write port
	input  logic                  cfg_we,
	input  logic [sgag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sgag_pkg::CFG_W-1:0]     cfg_data
);
	import sgag_pkg::*;

	// ---------------- config registers ----------------
	ext_t    extent_q [NDIM_REGS];
	stride_t stride_q [NDIM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NDIM_REGS; d++) begin
				extent_q[d] <= EXT_W'(1);
				// only the innermost stride defaults to one element
				stride_q[d] <= (d == NDIM_REGS - 1) ? STR_W'(1) : '0;
			end
		end else if (cfg_we) begin
			for (int d = 0; d < NDIM_REGS; d++) begin
				if (cfg_index == CFG_IDX_W'(CFG_EXTENT_BASE + d)) begin
					extent_q[d] <= ext_t'(cfg_data);
				end
				if (cfg_index == CFG_IDX_W'(CFG_STRIDE_BASE + d)) begin
					stride_q[d] <= stride_t'(cfg_data);
				end
			end
		end
	end

	// ---------------- input stage ----------------
	logic  valid_s1;
	cmd_t  cmd_s1;
	addr_t src_base_s1;
	addr_t dst_base_s1;
	logic  in_take;
	logic  adv;

	logic      out_valid_q;
	walk_res_t res_q;
	logic      contig_q;

	walk_res_t walk_res;
	logic      walk_active;
	logic      contig;

	// stage 1 moves on whenever the result register is empty or draining
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1      <= cmd_t'(cmd);
			src_base_s1 <= src_base;
			dst_base_s1 <= dst_base;
		end
	end

	// ---------------- walk and contiguity ----------------
	// the walk state updates in the same edge that loads the result register
	sgag_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.cmd         (cmd_s1),
		.src_base    (src_base_s1),
		.dst_base    (dst_base_s1),
		.extent      (extent_q),
		.stride      (stride_q),
		.res         (walk_res),
		.walk_active (walk_active)
	);

	// flag comes from config alone and rides along with every result
	sgag_contig u_contig (
		.extent     (extent_q),
		.stride     (stride_q),
		.contiguous (contig)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q    <= walk_res;
			contig_q <= contig;
		end
	end

	assign out_valid          = out_valid_q;
	assign valid_res          = res_q.valid_res;
	assign src_addr           = res_q.src_addr;
	assign dst_addr           = res_q.dst_addr;
	assign last               = res_q.last;
	assign already_contiguous = contig_q;

	// ---------------- checks ----------------
	`SGAG_ASSERT_IMP(a_stall_only_when_blocked, in_stall, out_valid && out_stall)
	`SGAG_ASSERT_NEXT(a_start_result_empty, adv && (cmd_s1 == CMD_START), out_valid && !valid_res && !last)
	`SGAG_ASSERT_NEXT(a_last_ends_walk, adv && walk_res.last, !walk_active)
	`SGAG_ASSERT_IMP(a_invalid_no_addr, out_valid && !valid_res, !last && (src_addr == '0) && (dst_addr == '0))

endmodule
